>>> design/btnth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnth_pkg
// Shared types, codes and constants of the button tap/hold mode engine.
// ----------------------------------------------------------------------------
package btnth_pkg;

  // time and register widths
  localparam int TimeW  = 48;
  localparam int MsW    = 16;
  localparam int UsW    = 26;   // 65535 ms in microseconds fits in 26 bits
  localparam int CodesW = 32;
  localparam int BothW  = 64;
  localparam int IdxW   = 3;
  localparam int MaxEv  = 3;
  localparam int CntW   = 2;

  localparam logic [UsW-1:0] UsPerMs = UsW'(1000);

  // codes per set and the resulting mask on a 32-bit code field
  localparam int CodesPerSet = 4;
  localparam int CodeBits    = (CodesPerSet >= 4) ? CodesW : 8 * CodesPerSet;
  localparam logic [CodesW-1:0] CodeMask =
    (CodeBits >= CodesW) ? {CodesW{1'b1}} : CodesW'((64'd1 << CodeBits) - 64'd1);

  // operating modes
  typedef enum logic [2:0] {
    ModeNormal   = 3'd0,
    ModeSticky   = 3'd1,
    ModeOverlap  = 3'd2,
    ModeEarly    = 3'd3,
    ModeExcl     = 3'd4,
    ModeExclLong = 3'd5
  } mode_e;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    RegMode        = 3'd0,
    RegDebounce    = 3'd1,
    RegExclHold    = 3'd2,
    RegExclLong    = 3'd3,
    RegOverlapHold = 3'd4,
    RegEarlyWindow = 3'd5,
    RegTapDelay    = 3'd6,
    RegCodes       = 3'd7
  } reg_idx_e;

  // action sets
  localparam logic SetPrimary   = 1'b0;
  localparam logic SetSecondary = 1'b1;

  // reset values in milliseconds
  localparam logic [MsW-1:0] DebounceRst    = MsW'(10);
  localparam logic [MsW-1:0] ExclHoldRst    = MsW'(200);
  localparam logic [MsW-1:0] ExclLongRst    = MsW'(600);
  localparam logic [MsW-1:0] OverlapHoldRst = MsW'(200);
  localparam logic [MsW-1:0] EarlyWindowRst = MsW'(200);
  localparam logic [MsW-1:0] TapDelayRst    = MsW'(100);

  // configuration as seen by the datapath, durations held in microseconds
  typedef struct packed {
    mode_e              mode;
    logic [UsW-1:0]     debounce_us;
    logic [UsW-1:0]     excl_hold_us;
    logic [UsW-1:0]     excl_long_us;
    logic [UsW-1:0]     overlap_us;
    logic [UsW-1:0]     early_us;
    logic [UsW-1:0]     delay_us;
    logic [BothW-1:0]   codes;
  } cfg_t;

  // one event of a poll
  typedef struct packed {
    logic set;
    logic press;
  } ev_t;

  // all events of one poll
  typedef struct packed {
    ev_t [MaxEv-1:0] ev;
    logic [CntW-1:0] cnt;
  } batch_t;

  // milliseconds to microseconds
  function automatic logic [UsW-1:0] ms_to_us(input logic [MsW-1:0] ms);
    ms_to_us = UsW'(ms) * UsPerMs;
  endfunction

endpackage

>>> design/btnth_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnth_if
// Handshake channels of the button tap/hold mode engine: poll, event, config.
// ----------------------------------------------------------------------------

// one button poll
interface btnth_poll_if;
  logic        valid;
  logic        ready;
  logic        pressed;
  logic [47:0] now_us;
  modport source (output valid, pressed, now_us, input ready);
  modport sink   (input valid, pressed, now_us, output ready);
endinterface

// one press or release event
interface btnth_event_if;
  logic        valid;
  logic        ready;
  logic        action_set;
  logic [31:0] action_codes;
  logic        is_press;
  logic        last;
  modport source (output valid, action_set, action_codes, is_press, last, input ready);
  modport sink   (input valid, action_set, action_codes, is_press, last, output ready);
endinterface

// configuration register write
interface btnth_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/btnth_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnth_cfg
// Configuration register file; durations are converted to microseconds on
// write so the poll path sees them ready to add.
// ----------------------------------------------------------------------------
module btnth_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  btnth_cfg_if.sink          cfg_i,
  output btnth_pkg::cfg_t    cfg_o
);

  btnth_pkg::cfg_t cfg_q;
  logic            wr_en;
  logic [btnth_pkg::UsW-1:0] wr_us;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;
  assign wr_us       = btnth_pkg::ms_to_us(cfg_i.data[btnth_pkg::MsW-1:0]);

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= btnth_pkg::ModeNormal;
      cfg_q.debounce_us  <= btnth_pkg::ms_to_us(btnth_pkg::DebounceRst);
      cfg_q.excl_hold_us <= btnth_pkg::ms_to_us(btnth_pkg::ExclHoldRst);
      cfg_q.excl_long_us <= btnth_pkg::ms_to_us(btnth_pkg::ExclLongRst);
      cfg_q.overlap_us   <= btnth_pkg::ms_to_us(btnth_pkg::OverlapHoldRst);
      cfg_q.early_us     <= btnth_pkg::ms_to_us(btnth_pkg::EarlyWindowRst);
      cfg_q.delay_us     <= btnth_pkg::ms_to_us(btnth_pkg::TapDelayRst);
      cfg_q.codes        <= '0;
    end else if (wr_en) begin
      case (btnth_pkg::reg_idx_e'(cfg_i.index))
        btnth_pkg::RegMode:        cfg_q.mode <= btnth_pkg::mode_e'(cfg_i.data[2:0]);
        btnth_pkg::RegDebounce:    cfg_q.debounce_us  <= wr_us;
        btnth_pkg::RegExclHold:    cfg_q.excl_hold_us <= wr_us;
        btnth_pkg::RegExclLong:    cfg_q.excl_long_us <= wr_us;
        btnth_pkg::RegOverlapHold: cfg_q.overlap_us   <= wr_us;
        btnth_pkg::RegEarlyWindow: cfg_q.early_us     <= wr_us;
        btnth_pkg::RegTapDelay:    cfg_q.delay_us     <= wr_us;
        btnth_pkg::RegCodes:       cfg_q.codes        <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/btnth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnth_core
// Poll input register, button state and the per-mode decision logic that
// turns one poll into up to three events.
// ----------------------------------------------------------------------------
module btnth_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  btnth_poll_if.sink         poll_i,
  input  btnth_pkg::cfg_t    cfg_i,
  input  logic               buf_free_i,
  output logic               load_o,
  output btnth_pkg::batch_t  batch_o
);

  localparam int TW = btnth_pkg::TimeW;

  // input register
  logic          in_vld_q;
  logic          in_pr_q;
  logic [TW-1:0] in_now_q;
  logic          accept;
  logic          move;

  // button state
  logic          prim_q, prim_d;
  logic          sec_q, sec_d;
  logic [TW-1:0] chg_q, chg_d;
  logic [TW-1:0] hold_q, hold_d;
  logic          rel_pend_q, rel_pend_d;
  logic [TW-1:0] rel_dl_q, rel_dl_d;

  // time compares
  logic [TW:0]   now_x;
  logic [TW:0]   deb_end;
  logic [TW:0]   ov_end;
  logic [TW:0]   ex_end;
  logic [TW:0]   early_end;
  logic [TW:0]   sched_sum;
  logic [TW-1:0] sched_dl;
  logic [btnth_pkg::UsW-1:0] ex_hold_us;
  logic          due;

  btnth_pkg::batch_t batch;

  // handshake: the input register empties when the event buffer takes its batch
  assign move         = in_vld_q && buf_free_i;
  assign poll_i.ready = !in_vld_q || buf_free_i;
  assign accept       = poll_i.valid && poll_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_pr_q  <= poll_i.pressed;
      in_now_q <= poll_i.now_us;
    end
  end

  // deadlines, all one bit wider so they never wrap
  assign now_x      = {1'b0, in_now_q};
  assign ex_hold_us = (cfg_i.mode == btnth_pkg::ModeExclLong) ? cfg_i.excl_long_us
                                                              : cfg_i.excl_hold_us;
  assign deb_end    = {1'b0, chg_q}  + (TW+1)'(cfg_i.debounce_us);
  assign ov_end     = {1'b0, hold_q} + (TW+1)'(cfg_i.overlap_us);
  assign ex_end     = {1'b0, hold_q} + (TW+1)'(ex_hold_us);
  assign early_end  = {1'b0, hold_q} + (TW+1)'(cfg_i.early_us);
  assign sched_sum  = now_x + (TW+1)'(cfg_i.delay_us);
  assign sched_dl   = sched_sum[TW] ? {TW{1'b1}} : sched_sum[TW-1:0];
  assign due        = rel_pend_q && (in_now_q >= rel_dl_q);

  // per-mode decision for the poll in the input register
  always_comb begin
    logic pr;
    pr         = in_pr_q;
    prim_d     = prim_q;
    sec_d      = sec_q;
    chg_d      = chg_q;
    hold_d     = hold_q;
    rel_pend_d = rel_pend_q;
    rel_dl_d   = rel_dl_q;
    batch      = '0;

    // a delayed primary release that has come due goes first
    if (due) begin
      batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b0};
      batch.cnt           = batch.cnt + 2'd1;
      rel_pend_d          = 1'b0;
    end

    case (cfg_i.mode)
      btnth_pkg::ModeNormal: begin
        if (now_x >= deb_end) begin
          if (pr && !prim_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b1};
            batch.cnt           = batch.cnt + 2'd1;
            prim_d              = 1'b1;
            chg_d               = in_now_q;
          end else if (!pr && prim_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b0};
            batch.cnt           = batch.cnt + 2'd1;
            prim_d              = 1'b0;
            chg_d               = in_now_q;
          end
        end
      end
      btnth_pkg::ModeSticky: begin
        if (pr && !prim_q) begin
          prim_d              = 1'b1;
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b1};
          batch.cnt           = batch.cnt + 2'd1;
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b1};
          batch.cnt           = batch.cnt + 2'd1;
        end else if (!pr && prim_q) begin
          prim_d              = 1'b0;
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b0};
          batch.cnt           = batch.cnt + 2'd1;
        end
      end
      btnth_pkg::ModeOverlap: begin
        if (pr && !prim_q && !sec_q) begin
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b1};
          batch.cnt           = batch.cnt + 2'd1;
          prim_d              = 1'b1;
          hold_d              = in_now_q;
        end else if (pr && prim_q && !sec_q) begin
          if (now_x > ov_end) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b1};
            batch.cnt           = batch.cnt + 2'd1;
            sec_d               = 1'b1;
          end
        end else if (!pr) begin
          if (prim_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b0};
            batch.cnt           = batch.cnt + 2'd1;
            prim_d              = 1'b0;
          end
          if (sec_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b0};
            batch.cnt           = batch.cnt + 2'd1;
            sec_d               = 1'b0;
          end
        end
      end
      btnth_pkg::ModeEarly: begin
        if (pr && !prim_q && !sec_q) begin
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b1};
          batch.cnt           = batch.cnt + 2'd1;
          sec_d               = 1'b1;
          hold_d              = in_now_q;
        end else if (!pr && sec_q) begin
          batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b0};
          batch.cnt           = batch.cnt + 2'd1;
          // a tap inside the window also taps the primary set
          if (now_x < early_end) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b1};
            batch.cnt           = batch.cnt + 2'd1;
            rel_pend_d          = 1'b1;
            rel_dl_d            = sched_dl;
          end
          sec_d = 1'b0;
        end
      end
      btnth_pkg::ModeExcl, btnth_pkg::ModeExclLong: begin
        if (pr && !prim_q && !sec_q) begin
          prim_d = 1'b1;
          hold_d = in_now_q;
        end else if (pr && prim_q && !sec_q) begin
          if (now_x > ex_end) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b1};
            batch.cnt           = batch.cnt + 2'd1;
            prim_d              = 1'b0;
            sec_d               = 1'b1;
          end
        end else if (!pr) begin
          if (prim_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetPrimary, press: 1'b1};
            batch.cnt           = batch.cnt + 2'd1;
            rel_pend_d          = 1'b1;
            rel_dl_d            = sched_dl;
            prim_d              = 1'b0;
          end else if (sec_q) begin
            batch.ev[batch.cnt] = '{set: btnth_pkg::SetSecondary, press: 1'b0};
            batch.cnt           = batch.cnt + 2'd1;
            sec_d               = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // state advances when the poll's batch is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_q     <= 1'b0;
      sec_q      <= 1'b0;
      chg_q      <= '0;
      hold_q     <= '0;
      rel_pend_q <= 1'b0;
      rel_dl_q   <= '0;
    end else if (move) begin
      prim_q     <= prim_d;
      sec_q      <= sec_d;
      chg_q      <= chg_d;
      hold_q     <= hold_d;
      rel_pend_q <= rel_pend_d;
      rel_dl_q   <= rel_dl_d;
    end
  end

  assign load_o  = move;
  assign batch_o = batch;

  // a due delayed release always leads the batch
  a_due_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && due |-> batch.cnt != 2'd0 && batch.ev[0].set == btnth_pkg::SetPrimary
                    && !batch.ev[0].press)
    else $error("due delayed release not first in batch");

  // a held poll is not dropped while the buffer is busy
  a_hold_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !buf_free_i |=> in_vld_q && $stable(in_now_q))
    else $error("stalled poll lost");

  // a scheduled release deadline never lies before the poll time
  a_dl_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && rel_pend_d && !rel_pend_q |-> rel_dl_d >= in_now_q)
    else $error("release deadline before poll time");

endmodule

>>> design/btnth_evbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnth_evbuf
// Result register holding one poll's events, delivered one per cycle while
// event_o is ready, with the chosen set's action codes and the last-event mark.
// ----------------------------------------------------------------------------
module btnth_evbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  btnth_pkg::batch_t  batch_i,
  input  btnth_pkg::cfg_t    cfg_i,
  output logic               free_o,
  btnth_event_if.source      event_o
);

  localparam int CW = btnth_pkg::CntW;

  btnth_pkg::ev_t [btnth_pkg::MaxEv-1:0] ev_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] rd_q;
  logic          pop;
  logic          last_ev;
  logic          last_pop;
  btnth_pkg::ev_t cur;

  // read side
  assign cur      = ev_q[rd_q];
  assign last_ev  = (rd_q == cnt_q - 2'd1);
  assign pop      = event_o.valid && event_o.ready;
  assign last_pop = pop && last_ev;
  assign free_o   = (cnt_q == '0) || last_pop;

  assign event_o.valid        = (cnt_q != '0);
  assign event_o.action_set   = cur.set;
  assign event_o.is_press     = cur.press;
  assign event_o.last         = last_ev;
  assign event_o.action_codes = btnth_pkg::CodeMask &
    (cur.set ? cfg_i.codes[btnth_pkg::BothW-1:btnth_pkg::CodesW]
             : cfg_i.codes[btnth_pkg::CodesW-1:0]);

  // count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
      rd_q  <= '0;
    end else if (last_pop) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (pop) begin
      rd_q  <= rd_q + 2'd1;
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= batch_i.ev;
    end
  end

  // read pointer stays inside the batch
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> rd_q < cnt_q)
    else $error("read pointer beyond batch");

  // a new batch only lands in a buffer that is empty or handing out its last event
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("batch loaded over pending events");

  // an event that is not the last one is followed by the next of the batch
  a_next_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !last_ev |=> event_o.valid && $stable(cnt_q) && rd_q == $past(rd_q) + 2'd1)
    else $error("batch not continued");

endmodule

>>> design/button_tap_hold_mode_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_tap_hold_mode_engine_unit
// Button tap/hold engine: turns timed button polls into press and release
// events of a primary and a secondary action set.
// ----------------------------------------------------------------------------
// A poll is registered in the input register on acceptance and decided there;
// once the result register is free, its zero to three events move into the
// result register, from which the first event is offered on event_o. The
// result register drains one event per cycle while event_o is ready, and a
// poll giving k events holds the channel until all k are taken; polls keep
// flowing at one per cycle while the result register is free or emptying,
// with one more poll waiting in the input register.
// Configuration writes are always accepted and must only be made while no
// poll is in flight; durations are kept in microseconds internally.
module button_tap_hold_mode_engine_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  btnth_cfg_if.sink      cfg_i,
  btnth_poll_if.sink     poll_i,
  btnth_event_if.source  event_o
);

  btnth_pkg::cfg_t   cfg;
  btnth_pkg::batch_t batch;
  logic              load;
  logic              buf_free;

  // configuration registers
  btnth_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // poll register and mode logic
  btnth_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_i     (poll_i),
    .cfg_i      (cfg),
    .buf_free_i (buf_free),
    .load_o     (load),
    .batch_o    (batch)
  );

  // result register
  btnth_evbuf u_evbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .batch_i (batch),
    .cfg_i   (cfg),
    .free_o  (buf_free),
    .event_o (event_o)
  );

endmodule

>>> bench/tb_button_tap_hold_mode_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_tap_hold_mode_engine_unit
// Self-checking bench for the button tap/hold engine. Timed button polls are
// driven through the poll channel, and a model of the engine predicts every
// press and release event. The event channel is checked item by item. The
// run starts with a directed pass through each mode and its corner cases,
// then moves through twelve register settings with random press sequences.
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_button_tap_hold_mode_engine_unit;

  localparam int               NumPhases      = 12;
  localparam int               ItemsPerPhase  = 26;
  localparam int               SettleCycles   = 8;
  localparam int               DrainCycles    = 20;
  localparam int               HoldOffCycles  = 300;
  localparam int               MaxSenderGap   = 60;
  localparam int               WatchdogLimit  = 5000;
  localparam logic [63:0]      UsPerMs64      = 64'd1000;
  localparam logic [63:0]      TimeMax64      = 64'hFFFF_FFFF_FFFF;

  // one press or release event as seen on the event channel
  typedef struct packed {
    logic        action_set;
    logic [31:0] codes;
    logic        press;
    logic        last;
  } tap_event_t;

  // engine model and queue of events still to arrive
  class tap_hold_scoreboard;
    logic [2:0]   cfg_mode;
    logic [15:0]  cfg_debounce;
    logic [15:0]  cfg_excl_hold;
    logic [15:0]  cfg_excl_long;
    logic [15:0]  cfg_overlap;
    logic [15:0]  cfg_early;
    logic [15:0]  cfg_delay;
    logic [63:0]  cfg_codes;

    bit           prim_act;
    bit           sec_act;
    bit           rel_pending;
    logic [47:0]  last_change;
    logic [47:0]  hold_start;
    logic [47:0]  rel_deadline;

    tap_event_t   batch[$];
    tap_event_t   pending_events[$];
    int           n_polls;
    int           n_events;
    int           n_errors;

    function new();
      cfg_mode      = btnth_pkg::ModeNormal;
      cfg_debounce  = btnth_pkg::DebounceRst;
      cfg_excl_hold = btnth_pkg::ExclHoldRst;
      cfg_excl_long = btnth_pkg::ExclLongRst;
      cfg_overlap   = btnth_pkg::OverlapHoldRst;
      cfg_early     = btnth_pkg::EarlyWindowRst;
      cfg_delay     = btnth_pkg::TapDelayRst;
      cfg_codes     = '0;
      prim_act      = 1'b0;
      sec_act       = 1'b0;
      rel_pending   = 1'b0;
      last_change   = '0;
      hold_start    = '0;
      rel_deadline  = '0;
      n_polls       = 0;
      n_events      = 0;
      n_errors      = 0;
    endfunction

    function void write_reg(btnth_pkg::reg_idx_e idx, logic [63:0] d);
      case (idx)
        btnth_pkg::RegMode:        cfg_mode      = d[2:0];
        btnth_pkg::RegDebounce:    cfg_debounce  = d[15:0];
        btnth_pkg::RegExclHold:    cfg_excl_hold = d[15:0];
        btnth_pkg::RegExclLong:    cfg_excl_long = d[15:0];
        btnth_pkg::RegOverlapHold: cfg_overlap   = d[15:0];
        btnth_pkg::RegEarlyWindow: cfg_early     = d[15:0];
        btnth_pkg::RegTapDelay:    cfg_delay     = d[15:0];
        btnth_pkg::RegCodes:       cfg_codes     = d;
        default: ;
      endcase
    endfunction

    // at most three events per poll, the rest are dropped
    function void add_event(logic action_set, logic press);
      tap_event_t ev;
      ev.action_set = action_set;
      ev.codes      = (action_set ? cfg_codes[63:32] : cfg_codes[31:0]) & btnth_pkg::CodeMask;
      ev.press      = press;
      ev.last       = 1'b0;
      if (batch.size() < btnth_pkg::MaxEv) batch.push_back(ev);
    endfunction

    // deadline saturates at the top of the 48-bit time range
    function void schedule_release(logic [47:0] t);
      logic [63:0] d;
      d = 64'(t) + 64'(cfg_delay) * UsPerMs64;
      rel_deadline = (d > TimeMax64) ? 48'hFFFF_FFFF_FFFF : d[47:0];
      rel_pending  = 1'b1;
    endfunction

    function void run_exclusive(logic p, logic [47:0] t, logic [15:0] hold_ms);
      if (p && !prim_act && !sec_act) begin
        prim_act   = 1'b1;
        hold_start = t;
      end else if (p && prim_act && !sec_act) begin
        if (64'(t) > 64'(hold_start) + 64'(hold_ms) * UsPerMs64) begin
          add_event(btnth_pkg::SetSecondary, 1'b1);
          prim_act = 1'b0;
          sec_act  = 1'b1;
        end
      end else if (!p) begin
        if (prim_act) begin
          add_event(btnth_pkg::SetPrimary, 1'b1);
          schedule_release(t);
          prim_act = 1'b0;
        end else if (sec_act) begin
          add_event(btnth_pkg::SetSecondary, 1'b0);
          sec_act = 1'b0;
        end
      end
    endfunction

    function void predict_poll(logic p, logic [47:0] t);
      logic [63:0] t64;
      t64 = 64'(t);
      batch.delete();
      n_polls++;
      // a due delayed release goes out ahead of the mode logic
      if (rel_pending && t >= rel_deadline) begin
        add_event(btnth_pkg::SetPrimary, 1'b0);
        rel_pending = 1'b0;
      end
      case (cfg_mode)
        btnth_pkg::ModeNormal: begin
          if (t64 >= 64'(last_change) + 64'(cfg_debounce) * UsPerMs64) begin
            if (p && !prim_act) begin
              add_event(btnth_pkg::SetPrimary, 1'b1);
              prim_act    = 1'b1;
              last_change = t;
            end else if (!p && prim_act) begin
              add_event(btnth_pkg::SetPrimary, 1'b0);
              prim_act    = 1'b0;
              last_change = t;
            end
          end
        end
        btnth_pkg::ModeSticky: begin
          if (p && !prim_act) begin
            prim_act = 1'b1;
            add_event(btnth_pkg::SetPrimary, 1'b1);
            add_event(btnth_pkg::SetSecondary, 1'b1);
          end else if (!p && prim_act) begin
            prim_act = 1'b0;
            add_event(btnth_pkg::SetSecondary, 1'b0);
          end
        end
        btnth_pkg::ModeOverlap: begin
          if (p && !prim_act && !sec_act) begin
            add_event(btnth_pkg::SetPrimary, 1'b1);
            prim_act   = 1'b1;
            hold_start = t;
          end else if (p && prim_act && !sec_act) begin
            if (t64 > 64'(hold_start) + 64'(cfg_overlap) * UsPerMs64) begin
              add_event(btnth_pkg::SetSecondary, 1'b1);
              sec_act = 1'b1;
            end
          end else if (!p) begin
            if (prim_act) begin
              add_event(btnth_pkg::SetPrimary, 1'b0);
              prim_act = 1'b0;
            end
            if (sec_act) begin
              add_event(btnth_pkg::SetSecondary, 1'b0);
              sec_act = 1'b0;
            end
          end
        end
        btnth_pkg::ModeEarly: begin
          if (p && !prim_act && !sec_act) begin
            add_event(btnth_pkg::SetSecondary, 1'b1);
            sec_act    = 1'b1;
            hold_start = t;
          end else if (!p && sec_act) begin
            add_event(btnth_pkg::SetSecondary, 1'b0);
            // quick release also taps the primary set
            if (t64 < 64'(hold_start) + 64'(cfg_early) * UsPerMs64) begin
              add_event(btnth_pkg::SetPrimary, 1'b1);
              schedule_release(t);
            end
            sec_act = 1'b0;
          end
        end
        btnth_pkg::ModeExcl:     run_exclusive(p, t, cfg_excl_hold);
        btnth_pkg::ModeExclLong: run_exclusive(p, t, cfg_excl_long);
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_events.push_back(batch[i]);
    endfunction

    function void check_event(tap_event_t act);
      tap_event_t exp;
      n_events++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event set=%0b codes=%h press=%0b last=%0b",
                 $time, act.action_set, act.codes, act.press, act.last);
        n_errors++;
        return;
      end
      exp = pending_events.pop_front();
      if (exp.action_set !== act.action_set) begin
        $display("%0t: action_set expected %0b actual %0b",
                 $time, exp.action_set, act.action_set);
        n_errors++;
      end
      if (exp.codes !== act.codes) begin
        $display("%0t: action_codes expected %h actual %h", $time, exp.codes, act.codes);
        n_errors++;
      end
      if (exp.press !== act.press) begin
        $display("%0t: is_press expected %0b actual %0b", $time, exp.press, act.press);
        n_errors++;
      end
      if (exp.last !== act.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, act.last);
        n_errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  btnth_cfg_if         cfg_bus ();
  btnth_poll_if        poll_bus ();
  btnth_event_if       event_bus ();

  tap_hold_scoreboard  sb;
  int                  tx_idle_pct;
  int                  rx_stall_pct;
  bit                  hold_off_req;
  int                  polls_sent;
  int                  cfg_sets;
  logic [47:0]         cur_time;
  logic [15:0]         ms_cfg [6];
  int unsigned         thr_us [6];

  button_tap_hold_mode_engine_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .poll_i  (poll_bus),
    .event_o (event_bus)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // handshake monitor feeding the model and the checker
  always @(posedge clk_i) begin
    tap_event_t act;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(btnth_pkg::reg_idx_e'(cfg_bus.index), cfg_bus.data);
      if (poll_bus.valid && poll_bus.ready)
        sb.predict_poll(poll_bus.pressed, poll_bus.now_us);
      if (event_bus.valid && event_bus.ready) begin
        act.action_set = event_bus.action_set;
        act.codes      = event_bus.action_codes;
        act.press      = event_bus.is_press;
        act.last       = event_bus.last;
        sb.check_event(act);
      end
    end
  end

  // event receiver: random stalls plus one long hold-off on request
  initial begin : event_sink
    int hold_left;
    hold_left = 0;
    event_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        event_bus.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles - 1;
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((cfg_bus.valid && cfg_bus.ready) || (poll_bus.valid && poll_bus.ready) ||
          (event_bus.valid && event_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: watchdog expired after %0d idle cycles", $time, WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  // one poll, preceded by a random sender gap
  task automatic send_poll(input logic p, input logic [47:0] t);
    int gap;
    gap = 0;
    while (gap < MaxSenderGap && $urandom_range(0, 99) < tx_idle_pct) gap++;
    repeat (gap) begin
      poll_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    poll_bus.valid   <= 1'b1;
    poll_bus.pressed <= p;
    poll_bus.now_us  <= t;
    do @(posedge clk_i); while (!poll_bus.ready);
    @(negedge clk_i);
    polls_sent++;
  endtask

  // stop sending and wait until every predicted event has been taken
  task automatic wait_quiet();
    poll_bus.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input btnth_pkg::reg_idx_e idx, input logic [63:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
  endtask

  // upper data bits are don't-care for the narrow registers
  function automatic logic [63:0] with_junk(input logic [15:0] v);
    logic [47:0] junk;
    junk = $urandom_range(0, 1) ? {16'($urandom), $urandom} : 48'd0;
    return {junk, v};
  endfunction

  // write all registers from mode, ms_cfg and the code word
  task automatic program_regs(input logic [2:0] m, input logic [63:0] codes);
    logic [60:0] junk;
    wait_quiet();
    junk = $urandom_range(0, 1) ? 61'({$urandom, $urandom}) : 61'd0;
    cfg_write(btnth_pkg::RegMode, {junk, m});
    cfg_write(btnth_pkg::RegDebounce,    with_junk(ms_cfg[0]));
    cfg_write(btnth_pkg::RegExclHold,    with_junk(ms_cfg[1]));
    cfg_write(btnth_pkg::RegExclLong,    with_junk(ms_cfg[2]));
    cfg_write(btnth_pkg::RegOverlapHold, with_junk(ms_cfg[3]));
    cfg_write(btnth_pkg::RegEarlyWindow, with_junk(ms_cfg[4]));
    cfg_write(btnth_pkg::RegTapDelay,    with_junk(ms_cfg[5]));
    cfg_write(btnth_pkg::RegCodes, codes);
    cfg_bus.valid <= 1'b0;
    foreach (ms_cfg[i]) thr_us[i] = int'(ms_cfg[i]) * 1000;
    cfg_sets++;
  endtask

  // time advance clustered around the configured durations
  function automatic logic [47:0] time_step();
    int unsigned thr;
    int          sel;
    thr = thr_us[$urandom_range(0, 5)];
    sel = $urandom_range(0, 9);
    case (sel)
      0:       time_step = '0;
      1, 2:    time_step = 48'($urandom_range(0, 50));
      3, 4, 5: time_step = 48'($urandom_range(0, 2 * thr + 1));
      6, 7:    time_step = 48'(thr) + 48'($urandom_range(0, 2)) - ((thr > 0) ? 48'd1 : 48'd0);
      default: time_step = 48'($urandom_range(0, 2000000));
    endcase
  endfunction

  // press/hold/release sequences with some random noise polls
  task automatic run_phase_items(input int count);
    int start;
    start = polls_sent;
    while (polls_sent - start < count) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(1, 5)) begin
          cur_time = cur_time + time_step();
          send_poll(1'b1, cur_time);
        end
        repeat ($urandom_range(1, 3)) begin
          cur_time = cur_time + time_step();
          send_poll(1'b0, cur_time);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          // occasional jump to anywhere in the time range, backwards too
          if ($urandom_range(0, 2) == 0)
            cur_time = {16'($urandom), $urandom};
          else
            cur_time = cur_time + time_step();
          send_poll(1'($urandom_range(0, 1)), cur_time);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    logic [2:0]  m;
    logic [63:0] codes;
    sb           = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_off_req = 1'b0;
    polls_sent   = 0;
    cfg_sets     = 0;
    cur_time     = '0;
    rst_ni       = 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= btnth_pkg::RegMode;
    cfg_bus.data     <= '0;
    poll_bus.valid   <= 1'b0;
    poll_bus.pressed <= 1'b0;
    poll_bus.now_us  <= '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // normal mode on reset values, debounce hides an early press and an early release
    send_poll(1'b1, 48'd5000);
    send_poll(1'b1, 48'd10000);
    send_poll(1'b0, 48'd15000);
    send_poll(1'b0, 48'd20000);

    // sticky: release lifts only the secondary set
    ms_cfg = '{16'd10, 16'd200, 16'd600, 16'd200, 16'd200, 16'd100};
    program_regs(btnth_pkg::ModeSticky, 64'hA1B2_C3D4_5E6F_7081);
    send_poll(1'b1, 48'd30000);
    send_poll(1'b0, 48'd32000);
    send_poll(1'b1, 48'd33000);

    // early mode with primary still marked active does nothing
    program_regs(btnth_pkg::ModeEarly, 64'h1122_3344_5566_7788);
    send_poll(1'b1, 48'd40000);

    // overlap: stale primary released, then hold adds the secondary set
    program_regs(btnth_pkg::ModeOverlap, 64'h1122_3344_5566_7788);
    send_poll(1'b0, 48'd42000);
    send_poll(1'b1, 48'd50000);
    send_poll(1'b1, 48'd250001);
    send_poll(1'b0, 48'd260000);

    // early mode taps, second tap overwrites the pending deadline
    program_regs(btnth_pkg::ModeEarly, 64'hDEAD_BEEF_0BAD_F00D);
    send_poll(1'b1, 48'd300000);
    send_poll(1'b0, 48'd350000);
    send_poll(1'b1, 48'd360000);
    send_poll(1'b0, 48'd370000);
    send_poll(1'b0, 48'd470000);

    // exclusive: long hold fires secondary, short one taps primary
    program_regs(btnth_pkg::ModeExcl, 64'hCAFE_F00D_1234_5678);
    send_poll(1'b1, 48'd500000);
    send_poll(1'b1, 48'd700001);
    send_poll(1'b0, 48'd710000);
    send_poll(1'b1, 48'd720000);
    send_poll(1'b0, 48'd730000);

    // unused mode still delivers the due delayed release
    program_regs(3'd7, 64'hCAFE_F00D_1234_5678);
    send_poll(1'b0, 48'd900000);

    // deadline saturation near the top of the time range
    ms_cfg = '{16'd10, 16'd200, 16'd600, 16'd200, 16'hFFFF, 16'hFFFF};
    program_regs(btnth_pkg::ModeEarly, 64'hFFFF_FFFF_FFFF_FFFF);
    send_poll(1'b1, 48'hFFFF_FFFF_FF00);
    send_poll(1'b0, 48'hFFFF_FFFF_FF80);
    send_poll(1'b0, 48'hFFFF_FFFF_FFFF);

    // random phases over modes, durations and idling patterns
    cur_time = 48'($urandom);
    for (int ph = 0; ph < NumPhases; ph++) begin
      m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 5));
      for (int i = 0; i < 6; i++) begin
        case (ph)
          8:       ms_cfg[i] = 16'd0;
          9:       ms_cfg[i] = 16'hFFFF;
          10:      ms_cfg[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
          default: ms_cfg[i] = 16'($urandom_range(0, (i == 0) ? 30 : 400));
        endcase
      end
      codes = (ph == 3) ? '1 : (ph == 4) ? '0 : {$urandom, $urandom};
      case ((ph + 3) % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      program_regs(m, codes);
      // sticky phase without idling: receiver holds off, the engine backs up
      if (ph == 1) hold_off_req = 1'b1;
      run_phase_items(ItemsPerPhase);
    end

    // drain and watch for stray events
    wait_quiet();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.pending_events.size() != 0) begin
      $display("%0t: %0d events never arrived", $time, sb.pending_events.size());
      sb.n_errors++;
    end

    $display("summary: %0d polls, %0d events checked over %0d register settings",
             sb.n_polls, sb.n_events, cfg_sets);
    $display("summary: all modes and unused codes, zero and full-scale durations, %s",
             "deadline saturation and a long receiver hold-off");
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
